>>> design/bcsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcsg_pkg
// Shared types and constants for the cubic Bezier segment generator.
// ============================================================================
package bcsg_pkg;

    localparam int unsigned STEPS_DEF = 100;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned WORK_W    = DATA_W + FRAC_W;
    localparam int unsigned T_W       = FRAC_W + 1;
    localparam int unsigned STEP_W    = 7;
    localparam int unsigned CMP_W     = 11;
    localparam int unsigned IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_LOAD,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_HOLD
    } t_seq_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] p0_x;
        logic signed [DATA_W-1:0] p0_y;
        logic signed [DATA_W-1:0] p1_x;
        logic signed [DATA_W-1:0] p1_y;
        logic signed [DATA_W-1:0] p2_x;
        logic signed [DATA_W-1:0] p2_y;
        logic signed [DATA_W-1:0] p3_x;
        logic signed [DATA_W-1:0] p3_y;
    } t_pts;

    typedef struct packed {
        logic                     start;
        logic signed [WORK_W-1:0] a;
        logic signed [WORK_W-1:0] b;
        logic [T_W-1:0]           t;
    } t_lerp_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORK_W-1:0] res;
    } t_lerp_rsp;

    typedef struct packed {
        logic           start;
        logic           first;
        logic [T_W-1:0] t;
    } t_job;

    typedef struct packed {
        logic                     idle;
        logic                     done;
        logic signed [DATA_W-1:0] from_x;
        logic signed [DATA_W-1:0] from_y;
        logic signed [DATA_W-1:0] to_x;
        logic signed [DATA_W-1:0] to_y;
    } t_seg;

endpackage
`default_nettype wire

>>> design/bcsg_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcsg_lerp
// Shared interpolation unit: a + round((b - a) * t / 2^16), three stages
// (subtract, multiply, round and add).
// ============================================================================
module bcsg_lerp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bcsg_pkg::t_lerp_req i_req,
    output bcsg_pkg::t_lerp_rsp      o_rsp
);
    import bcsg_pkg::*;

    localparam int unsigned DIFF_W = WORK_W + 1;
    localparam int unsigned MUL_W  = DIFF_W + T_W + 1;
    localparam int unsigned PROD_W = WORK_W + T_W + 1;

    logic                     r_v1, r_v2, r_v3;
    logic signed [WORK_W-1:0] r_a1, r_a2, r_res;
    logic signed [DIFF_W-1:0] r_diff;
    logic [T_W-1:0]           r_t;
    logic [PROD_W-1:0]        r_prod;

    logic signed [MUL_W-1:0]  w_mul;
    logic [PROD_W-1:0]        w_rnd;
    logic [PROD_W-1:0]        w_half;

    assign w_mul  = r_diff * $signed({1'b0, r_t});
    assign w_half = PROD_W'(1) << (FRAC_W - 1);
    assign w_rnd  = r_prod + w_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1   <= i_req.a;
        r_diff <= DIFF_W'(i_req.b) - DIFF_W'(i_req.a);
        r_t    <= i_req.t;
        r_a2   <= r_a1;
        r_prod <= w_mul[PROD_W-1:0];
        r_res  <= r_a2 + w_rnd[FRAC_W +: WORK_W];
    end

    assign o_rsp.done = r_v3;
    assign o_rsp.res  = r_res;

endmodule
`default_nettype wire

>>> design/bcsg_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcsg_seq
// Sequencer: runs six interpolations per coordinate through the shared unit,
// x first then y, and holds the previous curve point.
// ============================================================================
module bcsg_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bcsg_pkg::t_pts      i_pts,
    input  wire bcsg_pkg::t_job      i_job,
    input  wire logic                i_take,
    input  wire bcsg_pkg::t_lerp_rsp i_rsp,
    output bcsg_pkg::t_lerp_req      o_req,
    output bcsg_pkg::t_seg           o_seg
);
    import bcsg_pkg::*;

    localparam logic [2:0] LAST_OP = 3'd5;

    t_seq_state               r_state, n_state;
    logic [2:0]               r_op, n_op;
    logic                     r_coord, n_coord;
    logic [T_W-1:0]           r_t, n_t;
    logic signed [WORK_W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic signed [WORK_W-1:0] n_s0, n_s1, n_s2, n_s3;
    logic signed [DATA_W-1:0] r_from_x, r_from_y, r_to_x, r_to_y;
    logic signed [DATA_W-1:0] n_from_x, n_from_y, n_to_x, n_to_y;
    logic signed [DATA_W-1:0] r_prev_x, r_prev_y, n_prev_x, n_prev_y;

    logic [1:0]               w_j;
    logic signed [WORK_W-1:0] w_a, w_b;
    logic signed [WORK_W-1:0] w_q0, w_q1, w_q2, w_q3;
    logic [WORK_W-1:0]        w_rnd;

    // slot written by each step: level one 0,1,2; level two 0,1; level three 0
    function automatic logic [1:0] op_slot(input logic [2:0] op);
        logic [1:0] s;
        case (op)
            3'd0:    s = 2'd0;
            3'd1:    s = 2'd1;
            3'd2:    s = 2'd2;
            3'd3:    s = 2'd0;
            3'd4:    s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    assign w_j = op_slot(r_op);

    always_comb begin
        case (w_j)
            2'd0:    begin w_a = r_s0; w_b = r_s1; end
            2'd1:    begin w_a = r_s1; w_b = r_s2; end
            default: begin w_a = r_s2; w_b = r_s3; end
        endcase
    end

    assign w_q0  = r_coord ? {i_pts.p0_y, {FRAC_W{1'b0}}} : {i_pts.p0_x, {FRAC_W{1'b0}}};
    assign w_q1  = r_coord ? {i_pts.p1_y, {FRAC_W{1'b0}}} : {i_pts.p1_x, {FRAC_W{1'b0}}};
    assign w_q2  = r_coord ? {i_pts.p2_y, {FRAC_W{1'b0}}} : {i_pts.p2_x, {FRAC_W{1'b0}}};
    assign w_q3  = r_coord ? {i_pts.p3_y, {FRAC_W{1'b0}}} : {i_pts.p3_x, {FRAC_W{1'b0}}};
    assign w_rnd = i_rsp.res + (WORK_W'(1) << (FRAC_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_op     <= '0;
            r_coord  <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_coord  <= n_coord;
            r_prev_x <= n_prev_x;
            r_prev_y <= n_prev_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_s0     <= n_s0;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_s3     <= n_s3;
        r_from_x <= n_from_x;
        r_from_y <= n_from_y;
        r_to_x   <= n_to_x;
        r_to_y   <= n_to_y;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_coord  = r_coord;
        n_t      = r_t;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_s3     = r_s3;
        n_from_x = r_from_x;
        n_from_y = r_from_y;
        n_to_x   = r_to_x;
        n_to_y   = r_to_y;
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;

        o_req.start = 1'b0;
        o_req.a     = w_a;
        o_req.b     = w_b;
        o_req.t     = r_t;

        case (r_state)
            SQ_IDLE: begin
                if (i_job.start) begin
                    n_t      = i_job.t;
                    n_from_x = i_job.first ? i_pts.p0_x : r_prev_x;
                    n_from_y = i_job.first ? i_pts.p0_y : r_prev_y;
                    n_coord  = 1'b0;
                    n_state  = SQ_LOAD;
                end
            end
            SQ_LOAD: begin
                n_s0    = w_q0;
                n_s1    = w_q1;
                n_s2    = w_q2;
                n_s3    = w_q3;
                n_op    = '0;
                n_state = SQ_ISSUE;
            end
            SQ_ISSUE: begin
                o_req.start = 1'b1;
                n_state     = SQ_WAIT;
            end
            SQ_WAIT: begin
                if (i_rsp.done) begin
                    case (w_j)
                        2'd0:    n_s0 = i_rsp.res;
                        2'd1:    n_s1 = i_rsp.res;
                        default: n_s2 = i_rsp.res;
                    endcase
                    if (r_op == LAST_OP) begin
                        if (!r_coord) begin
                            n_to_x  = w_rnd[FRAC_W +: DATA_W];
                            n_coord = 1'b1;
                            n_state = SQ_LOAD;
                        end else begin
                            n_to_y  = w_rnd[FRAC_W +: DATA_W];
                            n_state = SQ_HOLD;
                        end
                    end else begin
                        n_op    = r_op + 3'd1;
                        n_state = SQ_ISSUE;
                    end
                end
            end
            SQ_HOLD: begin
                if (i_take) begin
                    n_prev_x = r_to_x;
                    n_prev_y = r_to_y;
                    n_state  = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    assign o_seg.idle   = (r_state == SQ_IDLE);
    assign o_seg.done   = (r_state == SQ_HOLD);
    assign o_seg.from_x = r_from_x;
    assign o_seg.from_y = r_from_y;
    assign o_seg.to_x   = r_to_x;
    assign o_seg.to_y   = r_to_y;

endmodule
`default_nettype wire

>>> design/cubic_bezier_segment_gen_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each item takes 12 interpolations through the single shared multiply unit,
// plus control point loads and hand-off; a new item is accepted only once the
// previous one has been handed off to the output register.
// An output register lets the next item start while a result waits.
// Reset (synchronous, active low) clears the control points, previous point
// and all handshake state.
// ============================================================================
// cubic_bezier_segment_gen_unit
// Cubic Bezier segment generator, de Casteljau evaluation in Q16 fixed point.
// ============================================================================
module cubic_bezier_segment_gen_unit #(
    parameter int unsigned STEPS = bcsg_pkg::STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bcsg_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bcsg_pkg::DATA_W-1:0]   i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [6:0] step_index
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [15:0] from_x, [31:16] from_y, [47:32] to_x, [63:48] to_y
    output logic [63:0]                        m_axis_tdata,
    output logic                               m_axis_tlast   // last_segment
);
    import bcsg_pkg::*;

    localparam int unsigned TAB_N = 2 ** STEP_W;

    t_pts                  r_pts, n_pts;
    logic                  r_last_pend;
    logic                  r_out_valid;
    logic                  r_out_last;
    logic [63:0]           r_out_data;

    logic [T_W-1:0]        w_t_tab [TAB_N];
    logic [STEP_W-1:0]     w_v;
    logic [CMP_W-1:0]      w_v_ext, w_v_eff_ext;
    logic [STEP_W-1:0]     w_v_eff;
    logic                  w_accept;
    logic                  w_take;
    t_job                  w_job;
    t_seg                  w_seg;
    t_lerp_req             w_req;
    t_lerp_rsp             w_rsp;

    // t = round(v / STEPS) in Q1.16
    for (genvar g = 0; g < TAB_N; g++) begin : g_ttab
        assign w_t_tab[g] = T_W'((g * (2 ** FRAC_W) + STEPS / 2) / STEPS);
    end

    assign w_v         = s_axis_tdata[STEP_W-1:0];
    assign w_v_ext     = CMP_W'(w_v);
    assign w_v_eff_ext = (w_v_ext > CMP_W'(STEPS)) ? CMP_W'(STEPS) : w_v_ext;
    assign w_v_eff     = w_v_eff_ext[STEP_W-1:0];

    assign s_axis_tready = w_seg.idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_take        = w_seg.done && (!r_out_valid || m_axis_tready);

    assign w_job.start = w_accept;
    assign w_job.first = (w_v_eff_ext == CMP_W'(1));
    assign w_job.t     = w_t_tab[w_v_eff];

    always_comb begin
        n_pts = r_pts;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_P0_X: n_pts.p0_x = i_cfg_data;
                REG_P0_Y: n_pts.p0_y = i_cfg_data;
                REG_P1_X: n_pts.p1_x = i_cfg_data;
                REG_P1_Y: n_pts.p1_y = i_cfg_data;
                REG_P2_X: n_pts.p2_x = i_cfg_data;
                REG_P2_Y: n_pts.p2_y = i_cfg_data;
                REG_P3_X: n_pts.p3_x = i_cfg_data;
                REG_P3_Y: n_pts.p3_y = i_cfg_data;
                default:  n_pts = r_pts;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts       <= '0;
            r_out_valid <= 1'b0;
            r_last_pend <= 1'b0;
        end else begin
            r_pts <= n_pts;
            if (w_accept) begin
                r_last_pend <= (w_v_eff_ext == CMP_W'(STEPS));
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {w_seg.to_y, w_seg.to_x, w_seg.from_y, w_seg.from_x};
            r_out_last <= r_last_pend;
        end
    end

    bcsg_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    bcsg_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (r_pts),
        .i_job   (w_job),
        .i_take  (w_take),
        .i_rsp   (w_rsp),
        .o_req   (w_req),
        .o_seg   (w_seg)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

>>> design/bcsg_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bcsg_chk
// Port-level checks for the cubic Bezier segment generator.
// ============================================================================
module bcsg_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // one item in flight: ready drops right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready still high after a transaction");

    // a new result only comes out of a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in progress");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind cubic_bezier_segment_gen_unit bcsg_chk u_bcsg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
